@@ hdl/blake2b_compress_unit_assert.svh @@
// Assertion macros for the BLAKE2b compression unit checker.
// No dependencies.
`ifndef BLAKE2B_COMPRESS_UNIT_ASSERT_SVH
`define BLAKE2B_COMPRESS_UNIT_ASSERT_SVH
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ hdl/b2c_pkg.sv @@
// Package for the BLAKE2b compression unit: payload structs, IV, sigma schedule.
// No dependencies.
`timescale 1ns / 1ps
package b2c_pkg;
   localparam int NumRounds = 12;

   typedef enum logic [0:0] {CMD_CHAIN = 1'b0, CMD_MSG = 1'b1} command_type;

   typedef struct packed {
      logic        command;
      logic [3:0]  word_index;
      logic [63:0] data;
      logic [63:0] counter_low;
      logic [63:0] counter_high;
      logic [63:0] flag_word0;
      logic [63:0] flag_word1;
   } req_type;

   typedef struct packed {
      logic [63:0] hash_word;
      logic [2:0]  out_index;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {ST_LOAD, ST_INIT, ST_ROUND, ST_EMIT} state_type;

   typedef struct packed {
      logic load_chain;
      logic load_msg;
      logic init_vec;
      logic do_half;
      logic half_sel;
      logic [3:0] round;
      logic fold;
   } cmd_type;

   function automatic logic [63:0] iv_word(input logic [2:0] i);
      case (i)
         3'd0: iv_word = 64'h6a09e667f3bcc908;
         3'd1: iv_word = 64'hbb67ae8584caa73b;
         3'd2: iv_word = 64'h3c6ef372fe94f82b;
         3'd3: iv_word = 64'ha54ff53a5f1d36f1;
         3'd4: iv_word = 64'h510e527fade682d1;
         3'd5: iv_word = 64'h9b05688c2b3e6c1f;
         3'd6: iv_word = 64'h1f83d9abfb41bd6b;
         default: iv_word = 64'h5be0cd19137e2179;
      endcase
   endfunction

   function automatic logic [63:0] sigma_row(input logic [3:0] r);
      case (r)
         4'd0, 4'd10: sigma_row = 64'hfedcba9876543210;
         4'd1, 4'd11: sigma_row = 64'h357b20c16df984ae;
         4'd2: sigma_row = 64'h491763eadf250c8b;
         4'd3: sigma_row = 64'h8f04a562ebcd1397;
         4'd4: sigma_row = 64'hd386cb1efa427509;
         4'd5: sigma_row = 64'h91ef57d438b0a6c2;
         4'd6: sigma_row = 64'hb8293670a4def15c;
         4'd7: sigma_row = 64'ha2684f05931ce7bd;
         4'd8: sigma_row = 64'h5a417d2c803b9ef6;
         default: sigma_row = 64'h0dc3e9bf5167482a;
      endcase
   endfunction

   function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
      rotr = (x >> n) | (x << (64 - n));
   endfunction
endpackage

@@ hdl/b2c_ctrl.sv @@
// Controller of the BLAKE2b compression unit: load, init, round and emit sequencing.
// Depends on b2c_pkg.
`timescale 1ns / 1ps
module b2c_ctrl import b2c_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    out_valid,
   input  logic    out_taken,
   output logic [2:0] out_idx,
   output cmd_type cmd
);
   state_type state_ff, state_in;
   logic [3:0] round_ff, round_in;
   logic half_ff, half_in;
   logic [2:0] emit_ff, emit_in;
   logic acc;

   assign acc = req_valid && (state_ff == ST_LOAD);

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      half_in = half_ff;
      emit_in = emit_ff;
      case (state_ff)
         ST_LOAD: begin
            if (acc && req_data.command == CMD_MSG && req_data.word_index == 4'hf) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            state_in = ST_ROUND;
            round_in = '0;
            half_in = 1'b0;
         end
         ST_ROUND: begin
            half_in = ~half_ff;
            if (half_ff) begin
               if (round_ff == 4'(NumRounds - 1)) begin
                  round_in = '0;
                  emit_in = '0;
                  state_in = ST_EMIT;
               end else begin
                  round_in = round_ff + 4'd1;
               end
            end
         end
         ST_EMIT: begin
            if (out_taken) begin
               emit_in = emit_ff + 3'd1;
               if (emit_ff == 3'd7) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != ST_LOAD);
      out_valid = (state_ff == ST_EMIT);
      out_idx = emit_ff;
      cmd = '0;
      cmd.load_chain = acc && req_data.command == CMD_CHAIN && !req_data.word_index[3];
      cmd.load_msg = acc && req_data.command == CMD_MSG;
      cmd.init_vec = (state_ff == ST_INIT);
      cmd.do_half = (state_ff == ST_ROUND);
      cmd.half_sel = half_ff;
      cmd.round = round_ff;
      cmd.fold = (state_ff == ST_ROUND) && half_ff && round_ff == 4'(NumRounds - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         round_ff <= '0;
         half_ff <= 1'b0;
         emit_ff <= '0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         half_ff <= half_in;
         emit_ff <= emit_in;
      end
   end
endmodule

@@ hdl/b2c_datapath.sv @@
// Datapath of the BLAKE2b compression unit: chaining value, message block, work vector, G units.
// Depends on b2c_pkg.
`timescale 1ns / 1ps
module b2c_datapath import b2c_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  cmd_type cmd,
   input  logic [2:0] out_idx,
   output logic [63:0] hash_word
);
   logic [63:0] h_ff [8];
   logic [63:0] m_ff [16];
   logic [63:0] v_ff [16];
   logic [63:0] v_out [16];
   logic [63:0] row;
   logic [63:0] cl_ff, ch_ff, f0_ff, f1_ff;

   assign row = sigma_row(cmd.round);

   always_comb begin
      logic [3:0] ia, ib, ic, id;
      logic [63:0] a, b, c, d, x, y;
      for (int i = 0; i < 16; i++) begin
         v_out[i] = v_ff[i];
      end
      for (int g = 0; g < 4; g++) begin
         if (!cmd.half_sel) begin
            ia = 4'(g); ib = 4'(g + 4); ic = 4'(g + 8); id = 4'(g + 12);
         end else begin
            ia = 4'(g); ib = 4'(4 + ((g + 1) % 4)); ic = 4'(8 + ((g + 2) % 4));
            id = 4'(12 + ((g + 3) % 4));
         end
         x = m_ff[row[(cmd.half_sel * 32) + g * 8 +: 4]];
         y = m_ff[row[(cmd.half_sel * 32) + g * 8 + 4 +: 4]];
         a = v_ff[ia]; b = v_ff[ib]; c = v_ff[ic]; d = v_ff[id];
         a = a + b + x;
         d = rotr(d ^ a, 32);
         c = c + d;
         b = rotr(b ^ c, 24);
         a = a + b + y;
         d = rotr(d ^ a, 16);
         c = c + d;
         b = rotr(b ^ c, 63);
         v_out[ia] = a; v_out[ib] = b; v_out[ic] = c; v_out[id] = d;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_msg) begin
         m_ff[req_data.word_index] <= req_data.data;
         if (req_data.word_index == 4'hf) begin
            cl_ff <= req_data.counter_low;
            ch_ff <= req_data.counter_high;
            f0_ff <= req_data.flag_word0;
            f1_ff <= req_data.flag_word1;
         end
      end
      if (cmd.init_vec) begin
         for (int i = 0; i < 8; i++) begin
            v_ff[i] <= h_ff[i];
         end
         for (int i = 0; i < 4; i++) begin
            v_ff[i + 8] <= iv_word(3'(i));
         end
         v_ff[12] <= iv_word(3'd4) ^ cl_ff;
         v_ff[13] <= iv_word(3'd5) ^ ch_ff;
         v_ff[14] <= iv_word(3'd6) ^ f0_ff;
         v_ff[15] <= iv_word(3'd7) ^ f1_ff;
      end else if (cmd.do_half) begin
         v_ff <= v_out;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= '0;
         end
      end else if (cmd.load_chain) begin
         h_ff[req_data.word_index[2:0]] <= req_data.data;
      end else if (cmd.fold) begin
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= h_ff[i] ^ v_out[i] ^ v_out[i + 8];
         end
      end
   end

   assign hash_word = h_ff[out_idx];
endmodule

@@ hdl/blake2b_compress_unit.sv @@
// BLAKE2b compression unit: one 64-bit word loads per transaction; message word 15
// starts a compression of an init step plus the half-round steps (one column or
// diagonal step of four G units each), then eight result transactions, one per cycle while rsp_stall is low.
// Depends on b2c_pkg, b2c_ctrl and b2c_datapath.
`timescale 1ns / 1ps
module blake2b_compress_unit import b2c_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);
   cmd_type cmd;
   logic [2:0] idx;
   logic [63:0] hw;

   b2c_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .out_valid(rsp_valid), .out_taken(rsp_valid && !rsp_stall),
      .out_idx(idx), .cmd
   );

   b2c_datapath u_dp (
      .clock, .reset, .req_data, .cmd, .out_idx(idx), .hash_word(hw)
   );

   always_comb begin
      rsp_data.hash_word = hw;
      rsp_data.out_index = idx;
      rsp_data.last = (idx == 3'd7);
   end
endmodule

@@ hdl/b2c_checker.sv @@
// Port checker for the BLAKE2b compression unit.
// Depends on b2c_pkg and blake2b_compress_unit_assert.svh.
`timescale 1ns / 1ps
`include "blake2b_compress_unit_assert.svh"
module b2c_port_props import b2c_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);
   `ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, req_stall)
   `ASSERT_IMPL(a_last_idx, clock, reset, rsp_valid, rsp_data.last == (rsp_data.out_index == 3'd7))
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
endmodule

bind blake2b_compress_unit b2c_port_props u_chk (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall, .rsp_data
);
